// ===== rtl/core/tee_pkg.sv =====
// ----------------------------------------------------------------------------
// tee_pkg
// Shared constants, command codes and port structs of the tile edit engine.
// ----------------------------------------------------------------------------
package tee_pkg;

    localparam int SHEET_BITS  = 7;
    localparam int SHEET_SIDE  = 1 << SHEET_BITS;
    localparam int ADDR_W      = 2 * SHEET_BITS;
    localparam int SHEET_DEPTH = 1 << ADDR_W;
    localparam int STACK_BITS  = 12;
    localparam int STACK_DEPTH = 1 << STACK_BITS;
    localparam int MAX_REGION  = 32;
    localparam int PIX_W       = 4;
    localparam int SIZE_W      = 6;
    localparam int CRD_W       = SHEET_BITS + 1;

    typedef enum logic [2:0] {
        K_WRITE,
        K_READ,
        K_BRUSH,
        K_ERASE,
        K_MIRH,
        K_MIRV,
        K_ROT,
        K_FILL
    } kind_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  wdata;
    } sheet_port_t;

    typedef struct packed {
        logic                  we;
        logic [STACK_BITS-1:0] addr;
        logic [ADDR_W-1:0]     wdata;
    } stack_port_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             fill_overflow;
    } result_t;

endpackage

// ===== rtl/core/tee_ram.sv =====
// ----------------------------------------------------------------------------
// tee_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module tee_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1 << AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/core/tee_ctrl.sv =====
// ----------------------------------------------------------------------------
// tee_ctrl
// Command sequencer: drives the sheet and fill stack memories one access per
// cycle and produces one result per command.
// ----------------------------------------------------------------------------
module tee_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [2:0]                       kind,
    input  logic [6:0]                       region_x,
    input  logic [6:0]                       region_y,
    input  logic [5:0]                       region_size,
    input  logic [6:0]                       point_x,
    input  logic [6:0]                       point_y,
    input  logic [2:0]                       brush_size,
    input  logic [3:0]                       pen_color,
    output tee_pkg::sheet_port_t             sheet_o,
    input  logic [tee_pkg::PIX_W-1:0]        sheet_rdata,
    output tee_pkg::stack_port_t             stack_o,
    input  logic [tee_pkg::ADDR_W-1:0]       stack_rdata,
    output logic                             res_valid,
    input  logic                             res_ready,
    output tee_pkg::result_t                 res
);

    import tee_pkg::*;

    localparam int BR_W = CRD_W + 1;
    localparam int SP_W = STACK_BITS + 1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_RD_WAIT,
        S_SCAN,
        S_GRD,
        S_GWR,
        S_F_SEED,
        S_F_SEEDW,
        S_F_POP,
        S_F_ADDR,
        S_F_TEST,
        S_F_PUSH,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [ADDR_W-1:0]     clr_reg;
    kind_t                 kind_reg;
    logic [SHEET_BITS-1:0] rx_reg, ry_reg, px_reg, py_reg;
    logic [SIZE_W-1:0]     n_reg;
    logic [2:0]            bs_reg;
    logic [PIX_W-1:0]      pen_reg;
    logic [PIX_W-1:0]      scan_val_reg;
    logic [CRD_W-1:0]      bx_reg, by_reg;
    logic [SIZE_W-1:0]     wx_reg, wy_reg, ix_reg, iy_reg;
    logic [2:0]            gi_reg;
    logic [2:0]            gcnt_reg;
    logic [PIX_W-1:0]      gval_reg [0:3];
    logic                  rd_pend_reg, rd_on_reg;
    logic [1:0]            rd_slot_reg;
    logic [PIX_W-1:0]      repl_reg;
    logic [ADDR_W-1:0]     cur_reg;
    logic [SP_W-1:0]       sp_reg;
    logic [1:0]            k_reg;
    logic [PIX_W-1:0]      value_reg;
    logic                  ovf_reg;

    // Decode of the registered command.
    logic [SIZE_W-1:0]     n_in;
    logic [CRD_W-1:0]      rxe, rye, rxn, ryn;
    logic signed [BR_W-1:0] bl, bt, br, bb, cl, ct, cr, cb, srxe, srye, srxn, sryn;
    logic                  brush_empty;
    logic                  seed_in;

    assign n_in = (region_size > SIZE_W'(MAX_REGION)) ? SIZE_W'(MAX_REGION) : region_size;
    assign rxe  = {1'b0, rx_reg};
    assign rye  = {1'b0, ry_reg};
    assign rxn  = rxe + CRD_W'(n_reg);
    assign ryn  = rye + CRD_W'(n_reg);

    assign srxe = $signed({1'b0, rxe});
    assign srye = $signed({1'b0, rye});
    assign srxn = $signed({1'b0, rxn});
    assign sryn = $signed({1'b0, ryn});
    assign bl   = $signed({2'b00, px_reg}) - $signed(BR_W'(bs_reg[2:1]));
    assign bt   = $signed({2'b00, py_reg}) - $signed(BR_W'(bs_reg[2:1]));
    assign br   = bl + $signed(BR_W'(bs_reg));
    assign bb   = bt + $signed(BR_W'(bs_reg));
    assign cl   = (bl < srxe) ? srxe : bl;
    assign ct   = (bt < srye) ? srye : bt;
    assign cr   = (br > srxn) ? srxn : br;
    assign cb   = (bb > sryn) ? sryn : bb;
    assign brush_empty = (cl >= cr) || (ct >= cb);

    assign seed_in = ({1'b0, px_reg} >= rxe) && ({1'b0, px_reg} < rxn) &&
                     ({1'b0, py_reg} >= rye) && ({1'b0, py_reg} < ryn);

    // Scan position and loop control.
    logic [CRD_W-1:0] sx, sy;
    logic             scan_last_x, scan_last;

    assign sx          = bx_reg + CRD_W'(ix_reg);
    assign sy          = by_reg + CRD_W'(iy_reg);
    assign scan_last_x = (ix_reg == wx_reg - SIZE_W'(1));
    assign scan_last   = scan_last_x && (iy_reg == wy_reg - SIZE_W'(1));

    // Positions of one swap or rotate group.
    logic [CRD_W-1:0] pos_x [0:3];
    logic [CRD_W-1:0] pos_y [0:3];
    logic [SIZE_W-1:0] fx, fy;
    logic [1:0]       rd_j, wr_j;
    logic             rd_on, wr_on;

    assign fx = n_reg - SIZE_W'(1) - ix_reg;
    assign fy = n_reg - SIZE_W'(1) - iy_reg;

    always_comb
    begin
        pos_x[0] = rxe + CRD_W'(ix_reg);
        pos_y[0] = rye + CRD_W'(iy_reg);
        pos_x[1] = rxe + CRD_W'(fy);
        pos_y[1] = rye + CRD_W'(ix_reg);
        pos_x[2] = rxe + CRD_W'(fx);
        pos_y[2] = rye + CRD_W'(fy);
        pos_x[3] = rxe + CRD_W'(iy_reg);
        pos_y[3] = rye + CRD_W'(fx);
        case (kind_reg)
            K_MIRH:
            begin
                pos_x[0] = rxe + CRD_W'(fx);
                pos_y[0] = rye + CRD_W'(iy_reg);
                pos_x[1] = rxe + CRD_W'(ix_reg);
                pos_y[1] = rye + CRD_W'(iy_reg);
            end
            K_MIRV:
            begin
                pos_x[0] = rxe + CRD_W'(ix_reg);
                pos_y[0] = rye + CRD_W'(fy);
                pos_x[1] = rxe + CRD_W'(ix_reg);
                pos_y[1] = rye + CRD_W'(iy_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Writes go round the group: slot 1 takes value 0, and slot 0 takes the last value.
    assign rd_j  = gi_reg[1:0];
    assign wr_j  = (gi_reg == gcnt_reg) ? 2'd0 : gi_reg[1:0];
    assign rd_on = !pos_x[rd_j][CRD_W-1] && !pos_y[rd_j][CRD_W-1];
    assign wr_on = !pos_x[wr_j][CRD_W-1] && !pos_y[wr_j][CRD_W-1];

    // Fill neighbors of the current pixel, in the order left, right, up, down.
    logic [SHEET_BITS-1:0] cx, cy, nx, ny;
    logic                  nb_in, fill_hit;

    assign cx = cur_reg[SHEET_BITS-1:0];
    assign cy = cur_reg[ADDR_W-1:SHEET_BITS];
    assign fill_hit = (sheet_rdata != pen_reg) && (sheet_rdata == repl_reg);

    always_comb
    begin
        nx    = cx;
        ny    = cy;
        nb_in = 1'b0;
        case (k_reg)
            2'd0:
            begin
                nx    = cx - SHEET_BITS'(1);
                nb_in = {1'b0, cx} > rxe;
            end
            2'd1:
            begin
                nx    = cx + SHEET_BITS'(1);
                nb_in = (cx != '1) && ({1'b0, cx} + CRD_W'(1) < rxn);
            end
            2'd2:
            begin
                ny    = cy - SHEET_BITS'(1);
                nb_in = {1'b0, cy} > rye;
            end
            default:
            begin
                ny    = cy + SHEET_BITS'(1);
                nb_in = (cy != '1) && ({1'b0, cy} + CRD_W'(1) < ryn);
            end
        endcase
    end

    // Memory port drive.
    always_comb
    begin
        sheet_o = '0;
        stack_o = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                sheet_o.we   = 1'b1;
                sheet_o.addr = clr_reg;
            end
            S_START:
            begin
                sheet_o.addr = {py_reg, px_reg};
                if (kind_reg == K_WRITE)
                begin
                    sheet_o.we    = 1'b1;
                    sheet_o.wdata = pen_reg;
                end
            end
            S_SCAN:
            begin
                sheet_o.we    = !sx[CRD_W-1] && !sy[CRD_W-1];
                sheet_o.addr  = {sy[SHEET_BITS-1:0], sx[SHEET_BITS-1:0]};
                sheet_o.wdata = scan_val_reg;
            end
            S_GRD:
            begin
                sheet_o.addr = {pos_y[rd_j][SHEET_BITS-1:0], pos_x[rd_j][SHEET_BITS-1:0]};
            end
            S_GWR:
            begin
                sheet_o.we    = wr_on;
                sheet_o.addr  = {pos_y[wr_j][SHEET_BITS-1:0], pos_x[wr_j][SHEET_BITS-1:0]};
                sheet_o.wdata = gval_reg[2'(gi_reg - 3'd1)];
            end
            S_F_SEED:
            begin
                sheet_o.addr = {py_reg, px_reg};
            end
            S_F_SEEDW:
            begin
                stack_o.we    = 1'b1;
                stack_o.wdata = {py_reg, px_reg};
            end
            S_F_POP:
            begin
                stack_o.addr = STACK_BITS'(sp_reg - SP_W'(1));
            end
            S_F_ADDR:
            begin
                sheet_o.addr = stack_rdata;
            end
            S_F_TEST:
            begin
                sheet_o.we    = fill_hit;
                sheet_o.addr  = cur_reg;
                sheet_o.wdata = pen_reg;
            end
            S_F_PUSH:
            begin
                stack_o.we    = nb_in && (sp_reg != SP_W'(STACK_DEPTH));
                stack_o.addr  = sp_reg[STACK_BITS-1:0];
                stack_o.wdata = {ny, nx};
            end
            default:
            begin
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.pixel_value   = value_reg;
    assign res.fill_overflow = ovf_reg;

    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            gval_reg[rd_slot_reg] <= rd_on_reg ? sheet_rdata : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            rd_pend_reg <= 1'b0;
            sp_reg      <= '0;
            gi_reg      <= '0;
            k_reg       <= '0;
        end
        else
        begin
            rd_pend_reg <= (state_reg == S_GRD);
            rd_slot_reg <= rd_j;
            rd_on_reg   <= rd_on;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + ADDR_W'(1);
                    if (clr_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        kind_reg  <= kind_t'(kind);
                        rx_reg    <= region_x;
                        ry_reg    <= region_y;
                        n_reg     <= n_in;
                        px_reg    <= point_x;
                        py_reg    <= point_y;
                        bs_reg    <= brush_size;
                        pen_reg   <= pen_color;
                        state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    value_reg <= '0;
                    ovf_reg   <= 1'b0;
                    ix_reg    <= '0;
                    iy_reg    <= '0;
                    gi_reg    <= '0;
                    state_reg <= S_DONE;
                    unique case (kind_reg)
                        K_WRITE:
                        begin
                        end
                        K_READ:
                        begin
                            state_reg <= S_RD_WAIT;
                        end
                        K_BRUSH:
                        begin
                            bx_reg       <= cl[CRD_W-1:0];
                            by_reg       <= ct[CRD_W-1:0];
                            wx_reg       <= SIZE_W'(cr - cl);
                            wy_reg       <= SIZE_W'(cb - ct);
                            scan_val_reg <= pen_reg;
                            if (!brush_empty)
                            begin
                                state_reg <= S_SCAN;
                            end
                        end
                        K_ERASE:
                        begin
                            bx_reg       <= rxe;
                            by_reg       <= rye;
                            wx_reg       <= n_reg;
                            wy_reg       <= n_reg;
                            scan_val_reg <= '0;
                            if (n_reg != '0)
                            begin
                                state_reg <= S_SCAN;
                            end
                        end
                        K_MIRH:
                        begin
                            wx_reg   <= n_reg >> 1;
                            wy_reg   <= n_reg;
                            gcnt_reg <= 3'd2;
                            if ((n_reg >> 1) != '0)
                            begin
                                state_reg <= S_GRD;
                            end
                        end
                        K_MIRV:
                        begin
                            wx_reg   <= n_reg;
                            wy_reg   <= n_reg >> 1;
                            gcnt_reg <= 3'd2;
                            if ((n_reg >> 1) != '0)
                            begin
                                state_reg <= S_GRD;
                            end
                        end
                        K_ROT:
                        begin
                            wx_reg   <= SIZE_W'((n_reg + SIZE_W'(1)) >> 1);
                            wy_reg   <= n_reg >> 1;
                            gcnt_reg <= 3'd4;
                            if ((n_reg >> 1) != '0)
                            begin
                                state_reg <= S_GRD;
                            end
                        end
                        K_FILL:
                        begin
                            if (seed_in)
                            begin
                                state_reg <= S_F_SEED;
                            end
                        end
                    endcase
                end
                S_RD_WAIT:
                begin
                    value_reg <= sheet_rdata;
                    state_reg <= S_DONE;
                end
                S_SCAN:
                begin
                    if (scan_last)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (scan_last_x)
                    begin
                        ix_reg <= '0;
                        iy_reg <= iy_reg + SIZE_W'(1);
                    end
                    else
                    begin
                        ix_reg <= ix_reg + SIZE_W'(1);
                    end
                end
                S_GRD:
                begin
                    if (gi_reg == gcnt_reg - 3'd1)
                    begin
                        gi_reg    <= 3'd1;
                        state_reg <= S_GWR;
                    end
                    else
                    begin
                        gi_reg <= gi_reg + 3'd1;
                    end
                end
                S_GWR:
                begin
                    if (gi_reg == gcnt_reg)
                    begin
                        gi_reg <= '0;
                        if (scan_last)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_GRD;
                            if (scan_last_x)
                            begin
                                ix_reg <= '0;
                                iy_reg <= iy_reg + SIZE_W'(1);
                            end
                            else
                            begin
                                ix_reg <= ix_reg + SIZE_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        gi_reg <= gi_reg + 3'd1;
                    end
                end
                S_F_SEED:
                begin
                    state_reg <= S_F_SEEDW;
                end
                S_F_SEEDW:
                begin
                    repl_reg  <= sheet_rdata;
                    sp_reg    <= SP_W'(1);
                    state_reg <= S_F_POP;
                end
                S_F_POP:
                begin
                    if (sp_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        sp_reg    <= sp_reg - SP_W'(1);
                        state_reg <= S_F_ADDR;
                    end
                end
                S_F_ADDR:
                begin
                    cur_reg   <= stack_rdata;
                    state_reg <= S_F_TEST;
                end
                S_F_TEST:
                begin
                    k_reg     <= '0;
                    state_reg <= fill_hit ? S_F_PUSH : S_F_POP;
                end
                S_F_PUSH:
                begin
                    if (nb_in && (sp_reg == SP_W'(STACK_DEPTH)))
                    begin
                        ovf_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (nb_in)
                        begin
                            sp_reg <= sp_reg + SP_W'(1);
                        end
                        k_reg <= k_reg + 2'd1;
                        if (k_reg == 2'd3)
                        begin
                            state_reg <= S_F_POP;
                        end
                    end
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("fill stack pointer beyond stack depth");

    a_ovf_fill: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.fill_overflow |-> kind_reg == K_FILL)
        else $error("overflow flag on a command other than flood fill");

    a_value_read: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.pixel_value != '0) |-> kind_reg == K_READ)
        else $error("pixel value on a command other than read");

    a_rd_capture: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> $past(state_reg == S_GRD))
        else $error("group capture without a group read");

endmodule

// ===== rtl/core/tile_edit_engine.sv =====
// ----------------------------------------------------------------------------
// tile_edit_engine
// Pixel sheet editor: write, read, brush, erase, mirror, rotate, flood fill.
// ----------------------------------------------------------------------------
// After reset the block clears its 128x128 sheet, one pixel per cycle, before
// it takes the first transaction. Every command yields one result. Each sheet
// access goes through the single sheet memory port: brush and erase write each
// pixel of their rectangle, a mirror reads and writes each swapped pair of a
// region of up to 32 pixels a side, rotate each group of four, and flood fill
// pops stack entries, paints matching pixels and pushes their neighbors.
module tile_edit_engine (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] kind,
    input  logic [6:0] region_x,
    input  logic [6:0] region_y,
    input  logic [5:0] region_size,
    input  logic [6:0] point_x,
    input  logic [6:0] point_y,
    input  logic [2:0] brush_size,
    input  logic [3:0] pen_color,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] pixel_value,
    output logic       fill_overflow
);

    import tee_pkg::*;

    sheet_port_t        sheet_p;
    stack_port_t        stack_p;
    logic [PIX_W-1:0]   sheet_rdata;
    logic [ADDR_W-1:0]  stack_rdata;
    logic               res_valid, res_ready;
    result_t            res;
    logic               out_valid_reg;
    result_t            out_reg;

    tee_ram #(.AW(ADDR_W), .DW(PIX_W)) u_sheet (
        .clk   (clk),
        .we    (sheet_p.we),
        .addr  (sheet_p.addr),
        .wdata (sheet_p.wdata),
        .rdata (sheet_rdata)
    );

    tee_ram #(.AW(STACK_BITS), .DW(ADDR_W)) u_stack (
        .clk   (clk),
        .we    (stack_p.we),
        .addr  (stack_p.addr),
        .wdata (stack_p.wdata),
        .rdata (stack_rdata)
    );

    tee_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .region_x    (region_x),
        .region_y    (region_y),
        .region_size (region_size),
        .point_x     (point_x),
        .point_y     (point_y),
        .brush_size  (brush_size),
        .pen_color   (pen_color),
        .sheet_o     (sheet_p),
        .sheet_rdata (sheet_rdata),
        .stack_o     (stack_p),
        .stack_rdata (stack_rdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // The result register lets the sequencer go on to the next transaction.
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_value   = out_reg.pixel_value;
    assign fill_overflow = out_reg.fill_overflow;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tile edit engine. It sends directed and random
// commands through the valid/stall handshake, predicts every result and the
// sheet contents with its own model, and compares each result transaction.
// ----------------------------------------------------------------------------
module testbench;
    import tee_pkg::*;

    localparam int CYCLE_LIMIT  = 20000000;
    localparam int DRAIN_CYCLES = 3000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] kind;
    logic [6:0] region_x;
    logic [6:0] region_y;
    logic [5:0] region_size;
    logic [6:0] point_x;
    logic [6:0] point_y;
    logic [2:0] brush_size;
    logic [3:0] pen_color;
    logic       out_valid;
    logic       out_stall;
    logic [3:0] pixel_value;
    logic       fill_overflow;

    logic [3:0] sheet_copy [0:SHEET_DEPTH-1];
    result_t    pending_results [$];
    int         error_count;
    int         cycle_count;
    bit         no_idle;

    tile_edit_engine u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .region_x     (region_x),
        .region_y     (region_y),
        .region_size  (region_size),
        .point_x      (point_x),
        .point_y      (point_y),
        .brush_size   (brush_size),
        .pen_color    (pen_color),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_value  (pixel_value),
        .fill_overflow(fill_overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Sheet model -----------------------------------------------------------
    function automatic logic [3:0] pixel_at(int x, int y);
        if (x < 0 || y < 0 || x >= SHEET_SIDE || y >= SHEET_SIDE)
            return 4'd0;
        return sheet_copy[y * SHEET_SIDE + x];
    endfunction

    function automatic void paint(int x, int y, logic [3:0] c);
        if (x >= 0 && y >= 0 && x < SHEET_SIDE && y < SHEET_SIDE)
            sheet_copy[y * SHEET_SIDE + x] = c;
    endfunction

    function automatic bit in_region(int x, int y, int rx, int ry, int n);
        return x >= 0 && y >= 0 && x < SHEET_SIDE && y < SHEET_SIDE
            && x >= rx && x < rx + n && y >= ry && y < ry + n;
    endfunction

    function automatic bit flood_region(int rx, int ry, int n, int sx, int sy,
                                        logic [3:0] pen);
        int         seeds [$];
        int         dx [4];
        int         dy [4];
        logic [3:0] target;
        int         a;
        int         x;
        int         y;
        int         nx;
        int         ny;
        dx = '{-1, 1, 0, 0};
        dy = '{0, 0, -1, 1};
        if (!in_region(sx, sy, rx, ry, n))
            return 1'b0;
        target = pixel_at(sx, sy);
        seeds.push_back(sy * SHEET_SIDE + sx);
        while (seeds.size() > 0)
        begin
            a = seeds.pop_back();
            x = a % SHEET_SIDE;
            y = a / SHEET_SIDE;
            if (pixel_at(x, y) == pen || pixel_at(x, y) != target)
                continue;
            paint(x, y, pen);
            for (int k = 0; k < 4; k++)
            begin
                nx = x + dx[k];
                ny = y + dy[k];
                if (!in_region(nx, ny, rx, ry, n))
                    continue;
                if (seeds.size() >= STACK_DEPTH)
                    return 1'b1;
                seeds.push_back(ny * SHEET_SIDE + nx);
            end
        end
        return 1'b0;
    endfunction

    function automatic result_t apply_command(kind_t k, int rx, int ry, int n,
                                              int px, int py, int bs,
                                              logic [3:0] pen);
        result_t    r;
        int         l;
        int         t;
        int         rr;
        int         b;
        int         tx;
        int         ty;
        int         old_y;
        logic [3:0] far_px;
        logic [3:0] near_px;
        logic [3:0] prev;
        logic [3:0] cur;
        r = '0;
        if (n > MAX_REGION)
            n = MAX_REGION;
        case (k)
            K_WRITE: paint(px, py, pen);
            K_READ:  r.pixel_value = pixel_at(px, py);
            K_BRUSH:
            begin
                l  = px - (bs >> 1);
                t  = py - (bs >> 1);
                rr = l + bs;
                b  = t + bs;
                if (l < rx) l = rx;
                if (t < ry) t = ry;
                if (rr > rx + n) rr = rx + n;
                if (b > ry + n) b = ry + n;
                for (int y = t; y < b; y++)
                    for (int x = l; x < rr; x++)
                        paint(x, y, pen);
            end
            K_ERASE:
                for (int y = ry; y < ry + n; y++)
                    for (int x = rx; x < rx + n; x++)
                        paint(x, y, 4'd0);
            K_MIRH:
                for (int y = 0; y < n; y++)
                    for (int x = 0; x < (n >> 1); x++)
                    begin
                        far_px  = pixel_at(rx + n - x - 1, ry + y);
                        near_px = pixel_at(rx + x, ry + y);
                        paint(rx + n - x - 1, ry + y, near_px);
                        paint(rx + x, ry + y, far_px);
                    end
            K_MIRV:
                for (int y = 0; y < (n >> 1); y++)
                    for (int x = 0; x < n; x++)
                    begin
                        far_px  = pixel_at(rx + x, ry + n - y - 1);
                        near_px = pixel_at(rx + x, ry + y);
                        paint(rx + x, ry + n - y - 1, near_px);
                        paint(rx + x, ry + y, far_px);
                    end
            K_ROT:
                for (int y = 0; y < (n >> 1); y++)
                    for (int x = 0; x < ((n + 1) >> 1); x++)
                    begin
                        tx   = x;
                        ty   = y;
                        prev = pixel_at(rx + x, ry + y);
                        for (int i = 0; i < 4; i++)
                        begin
                            old_y = ty;
                            ty    = tx;
                            tx    = n - old_y - 1;
                            cur   = pixel_at(rx + tx, ry + ty);
                            paint(rx + tx, ry + ty, prev);
                            prev  = cur;
                        end
                    end
            default: r.fill_overflow = flood_region(rx, ry, n, px, py, pen);
        endcase
        return r;
    endfunction

    // Handshake -------------------------------------------------------------
    task automatic send_command(kind_t k, int rx, int ry, int n, int px, int py,
                                int bs, int pen);
        if (!no_idle && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        kind        <= k;
        region_x    <= rx[6:0];
        region_y    <= ry[6:0];
        region_size <= n[5:0];
        point_x     <= px[6:0];
        point_y     <= py[6:0];
        brush_size  <= bs[2:0];
        pen_color   <= pen[3:0];
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(apply_command(k, rx[6:0], ry[6:0], n[5:0],
                                                px[6:0], py[6:0], bs[2:0],
                                                pen[3:0]));
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= !no_idle && ($urandom_range(99) < 27);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result transaction with nothing expected");
            else
            begin
                want = pending_results.pop_front();
                if (pixel_value !== want.pixel_value)
                    report_mismatch($sformatf("pixel_value %0h, expected %0h",
                                              pixel_value, want.pixel_value));
                if (fill_overflow !== want.fill_overflow)
                    report_mismatch($sformatf("fill_overflow %0b, expected %0b",
                                              fill_overflow, want.fill_overflow));
            end
        end
    end

    // Tests -----------------------------------------------------------------
    task automatic test_pixel_access();
        send_command(K_WRITE, 0, 0, 8, 0, 0, 1, 15);
        send_command(K_WRITE, 0, 0, 8, 127, 127, 1, 9);
        send_command(K_READ, 0, 0, 8, 0, 0, 0, 0);
        send_command(K_READ, 0, 0, 8, 127, 127, 0, 0);
        send_command(K_READ, 0, 0, 8, 5, 5, 0, 0);
    endtask

    task automatic test_brush();
        send_command(K_BRUSH, 10, 10, 8, 10, 10, 5, 7);
        send_command(K_BRUSH, 10, 10, 8, 17, 17, 7, 3);
        send_command(K_BRUSH, 10, 10, 8, 12, 12, 0, 6);
        send_command(K_BRUSH, 10, 10, 0, 12, 12, 3, 6);
        send_command(K_READ, 0, 0, 8, 11, 11, 0, 0);
    endtask

    task automatic test_region_transforms();
        send_command(K_MIRH, 8, 8, 8, 0, 0, 0, 0);
        send_command(K_MIRV, 8, 8, 7, 0, 0, 0, 0);
        send_command(K_ROT, 9, 9, 7, 0, 0, 0, 0);
        send_command(K_ROT, 120, 120, 63, 0, 0, 0, 0);
        send_command(K_MIRH, 100, 100, 32, 0, 0, 0, 0);
        send_command(K_ERASE, 124, 124, 8, 0, 0, 0, 0);
        send_command(K_READ, 0, 0, 8, 127, 127, 0, 0);
    endtask

    task automatic test_flood_fill();
        send_command(K_FILL, 8, 8, 16, 9, 9, 0, 4);
        send_command(K_FILL, 8, 8, 16, 9, 9, 0, 4);
        send_command(K_FILL, 8, 8, 16, 40, 40, 0, 2);
        send_command(K_FILL, 96, 96, 32, 127, 127, 0, 11);
        send_command(K_FILL, 8, 8, 0, 8, 8, 0, 1);
        send_command(K_READ, 0, 0, 8, 12, 20, 0, 0);
    endtask

    task automatic test_random_mix(int count);
        int    rx;
        int    ry;
        int    n;
        int    px;
        int    py;
        kind_t k;
        for (int i = 0; i < count; i++)
        begin
            // A quiet stretch with no idling on either side.
            no_idle = (i >= count / 3) && (i < count / 3 + 40);
            if (i == count / 2)
                wait_all_results();
            k  = kind_t'($urandom_range(7));
            rx = $urandom_range(127);
            ry = $urandom_range(127);
            if ($urandom_range(99) < 70)
                n = $urandom_range(1, 8);
            else if ($urandom_range(99) < 70)
                n = $urandom_range(0, 16);
            else
                n = $urandom_range(63);
            // Points mostly fall in or near the region so that brush, fill
            // and read see painted pixels.
            if ($urandom_range(99) < 80)
            begin
                px = (rx + $urandom_range(0, n + 1)) & 127;
                py = (ry + $urandom_range(0, n + 1)) & 127;
            end
            else
            begin
                px = $urandom_range(127);
                py = $urandom_range(127);
            end
            send_command(k, rx, ry, n, px, py, $urandom_range(7), $urandom_range(15));
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        out_stall   <= 1'b0;
        kind        <= K_WRITE;
        region_x    <= '0;
        region_y    <= '0;
        region_size <= '0;
        point_x     <= '0;
        point_y     <= '0;
        brush_size  <= '0;
        pen_color   <= '0;
        error_count = 0;
        cycle_count = 0;
        no_idle     = 1'b0;
        for (int i = 0; i < SHEET_DEPTH; i++)
            sheet_copy[i] = 4'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pixel_access();
        test_brush();
        test_region_transforms();
        test_flood_fill();
        test_random_mix(265);

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== tile_edit_engine.f =====
rtl/core/tee_pkg.sv
rtl/core/tee_ram.sv
rtl/core/tee_ctrl.sv
rtl/core/tile_edit_engine.sv
test/testbench.sv
